FILE: rtl/dqmm_pkg.sv
// Shared types and codes for the deque with running maximum and middle element.
// No dependencies; every other file of the block imports this package.
package dqmm_pkg;

   // Fixed field widths of the two channels
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Operation codes; unused codes behave as a query
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_START,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/dqmm_ifs.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on dqmm_pkg for the field widths.
interface dqmm_req_if;
   import dqmm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface dqmm_rsp_if;
   import dqmm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  popped_value;
   logic [COUNT_W-1:0]         item_count;
   logic signed [VALUE_W-1:0]  middle_value;
   logic signed [VALUE_W-1:0]  max_value;
   logic                       is_empty;

   modport source (output valid, output status, output popped_value, output item_count,
                   output middle_value, output max_value, output is_empty, input ready);
   modport sink   (input valid, input status, input popped_value, input item_count,
                   input middle_value, input max_value, input is_empty, output ready);
endinterface

FILE: rtl/deque_with_max_and_middle.sv
// Bounded double-ended queue in a ring memory, reporting max and middle element.
// Depends on dqmm_pkg and the channel interfaces in dqmm_ifs.sv.
//
// Usage:
//   req_ch carries one transaction per operation: op (push front/back, pop
//   front/back, query) and value. rsp_ch returns exactly one transaction per
//   request: status, popped value, count, middle element, maximum, empty flag.
//   req_ch.ready is high only while the block is idle; one request is worked
//   on at a time.
// Sequence: a sequencer reads the held elements one per cycle through the
//   single memory read port and a shared signed comparator. After acceptance
//   a request passes through an execute state, a pop state for a successful
//   pop (which needs one extra memory read), a start state and a scan over
//   the elements held after the operation before rsp_ch.valid rises.
// Back to back: a new request is not taken until the response is accepted;
//   the next request is taken in the cycle after the response.
// Stall: while rsp_ch.ready is low the response holds steady and no request
//   is taken.
// Reset: synchronous, active high; empties the queue at once (no memory
//   clearing pass is needed, only held entries are ever read).
module deque_with_max_and_middle #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   dqmm_req_if.sink   req_ch,
   dqmm_rsp_if.source rsp_ch
);
   import dqmm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // Sign-extend a stored element and keep the low bits of the result field
   function automatic logic [VALUE_W-1:0] to_field(input data_type d);
      logic signed [63:0] w;
      w = 64'(d);
      return w[VALUE_W-1:0];
   endfunction

   // Ring memory
   data_type mem [DEPTH];
   data_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   // Control and datapath registers
   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   data_type        value_ff, value_in;
   logic [AW-1:0]   front_ff, front_in;
   logic [CW-1:0]   count_ff, count_in;
   status_type      status_ff, status_in;
   logic [VALUE_W-1:0] popped_ff, popped_in;
   data_type        max_ff, max_in;
   data_type        mid_ff, mid_in;
   logic [AW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            pend_ff, pend_in;
   logic [CW-1:0]   pend_idx_ff, pend_idx_in;

   // Ring positions derived from front and count
   logic [CW:0]   back_sum, last_sum;
   logic [AW-1:0] back_pos, last_pos, front_dec, front_inc, ptr_inc;
   logic          is_push, is_pop, is_full, is_empty_q, scan_more, scan_done;
   logic          max_take;
   logic signed [63:0] value_ext;

   always_comb begin
      back_sum  = (CW+1)'(front_ff) + (CW+1)'(count_ff);
      last_sum  = back_sum - (CW+1)'(1);
      back_pos  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
      last_pos  = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
      front_dec = (front_ff == '0) ? LAST_A : front_ff - AW'(1);
      front_inc = (front_ff == LAST_A) ? '0 : front_ff + AW'(1);
      ptr_inc   = (ptr_ff == LAST_A) ? '0 : ptr_ff + AW'(1);
      is_push   = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);
      is_pop    = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK);
      is_full   = (count_ff >= DEPTH_C);
      is_empty_q = (count_ff == '0);
      scan_more = (issue_ff < count_ff);
      scan_done = !scan_more && !pend_ff;
      max_take  = (pend_idx_ff == '0) || (rd_data_ff > max_ff);
      value_ext = 64'(req_ch.value);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (is_pop && !is_empty_q) state_in = ST_POP;
            else                       state_in = ST_START;
         end
         ST_POP:   state_in = ST_START;
         ST_START: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in       = op_ff;
      value_in    = value_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      popped_in   = popped_ff;
      max_in      = max_ff;
      mid_in      = mid_ff;
      ptr_in      = ptr_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            op_in     = req_ch.op;
            value_in  = value_ext[DATA_WIDTH-1:0];
            status_in = STATUS_OK;
            popped_in = '0;
         end
         ST_EXEC: begin
            if (is_push) begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  if (op_ff == OP_PUSH_FRONT) front_in = front_dec;
               end
            end else if (is_pop && is_empty_q) begin
               status_in = STATUS_EMPTY;
            end
         end
         ST_POP: begin
            popped_in = to_field(rd_data_ff);
            count_in  = count_ff - CW'(1);
            if (op_ff == OP_POP_FRONT) front_in = front_inc;
         end
         ST_START: begin
            ptr_in   = front_ff;
            issue_in = '0;
            max_in   = '0;
            mid_in   = '0;
         end
         ST_SCAN: begin
            // Issue one read per cycle, fold in the element read last cycle
            if (scan_more) begin
               ptr_in      = ptr_inc;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
            end
            if (pend_ff) begin
               if (max_take) max_in = rd_data_ff;
               if (pend_idx_ff == (count_ff >> 1)) mid_in = rd_data_ff;
            end
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   // Handshake and memory port controls
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_ch.valid = (state_ff == ST_RESP);
      wr_en   = (state_ff == ST_EXEC) && is_push && !is_full;
      wr_addr = (op_ff == OP_PUSH_FRONT) ? front_dec : back_pos;
      case (state_ff)
         ST_EXEC: rd_addr = (op_ff == OP_POP_FRONT) ? front_ff : last_pos;
         default: rd_addr = ptr_ff;
      endcase
   end

   // Response fields
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.popped_value = popped_ff;
   assign rsp_ch.item_count   = COUNT_W'(count_ff);
   assign rsp_ch.middle_value = to_field(mid_ff);
   assign rsp_ch.max_value    = to_field(max_ff);
   assign rsp_ch.is_empty     = is_empty_q;

   // Memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= value_ff;
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      max_ff      <= max_in;
      mid_ff      <= mid_in;
      ptr_ff      <= ptr_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("held count exceeds depth");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a response is pending");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_empty |->
         rsp_ch.max_value == '0 && rsp_ch.middle_value == '0)
      else $error("empty queue reports nonzero max or middle");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && scan_done |=> state_ff == ST_RESP && !pend_ff)
      else $error("scan did not hand over to response");
`endif

endmodule
